### sv/signed_int_to_decimal_ascii_assert.svh
// assertion macros shared by the decimal ascii converter modules
// depends on nothing; included by files that carry concurrent assertions
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SIDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sida assertion failed");

// next-cycle implication
`define SIDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sida assertion failed");

`else

`define SIDA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SIDA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/sida_pkg.sv
// shared types and constants of the decimal ascii converter
// no dependencies
package sida_pkg;

    localparam int VALUE_W       = 32;
    localparam int CHAR_W        = 8;
    localparam int NUM_DIGITS    = 10;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
    localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef logic [NUM_DIGITS-1:0][3:0] t_bcd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_ALIGN,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic align;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic last_digit;
        logic neg;
        logic out_free;
    } t_dp_sts;

endpackage

### sv/sida_if.sv
// stream interfaces of the decimal ascii converter
// depends on sida_pkg
interface sida_value_if import sida_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sida_char_if import sida_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

### sv/sida_datapath.sv
// datapath: magnitude, shift-and-add-3 binary to bcd, digit select, output register
// depends on sida_pkg, sida_if, signed_int_to_decimal_ascii_assert.svh
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_datapath import sida_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    sida_char_if.source               o_out
);

    // one shift-and-add-3 step for a single input bit
    function automatic t_bcd dd_bit(input t_bcd bcd, input logic b);
        t_bcd adj;
        adj = bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd[d] >= 4'd5) begin
                adj[d] = bcd[d] + 4'd3;
            end
        end
        return {adj[NUM_DIGITS-1:0], b} >> 0 == 0 ? t_bcd'(0) : t_bcd'({adj, b});
    endfunction

    logic [VALUE_W-1:0]    r_mag;
    logic [VALUE_W-1:0]    n_mag;
    t_bcd                  r_bcd;
    t_bcd                  n_bcd;
    logic                  r_neg;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [DIG_IDX_W-1:0]  r_dig_idx;
    logic [DIG_IDX_W-1:0]  n_lead;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;
    logic [VALUE_W-1:0]    w_raw;
    logic [VALUE_W-1:0]    w_abs;
    t_bcd                  w_step [BITS_PER_STEP+1];

    assign w_raw = i_value;
    assign w_abs = w_raw[VALUE_W-1] ? (~w_raw + 1'b1) : w_raw;

    // four dependent bit steps per cycle, msb first
    always_comb begin
        w_step[0] = r_bcd;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            w_step[k+1] = dd_bit(w_step[k], r_mag[VALUE_W-1-k]);
        end
        n_bcd = w_step[BITS_PER_STEP];
        n_mag = r_mag << BITS_PER_STEP;
    end

    // highest nonzero digit, zero keeps index 0
    always_comb begin
        n_lead = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d] != 4'd0) begin
                n_lead = DIG_IDX_W'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= w_abs;
            r_bcd <= '0;
            r_neg <= w_raw[VALUE_W-1];
        end else if (i_cmd.conv) begin
            r_mag <= n_mag;
            r_bcd <= n_bcd;
        end
        if (i_cmd.align) begin
            r_dig_idx <= n_lead;
        end else if (i_cmd.emit_digit) begin
            r_dig_idx <= r_dig_idx - 1'b1;
        end
        if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= CHAR_ZERO + {4'd0, r_bcd[r_dig_idx]};
            r_out_last <= (r_dig_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.conv) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.conv_done  = (r_cnt == STEP_CNT_W'(CONV_STEPS - 1));
    assign o_sts.last_digit = (r_dig_idx == '0);
    assign o_sts.neg        = r_neg;
    assign o_sts.out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    `SIDA_ASSERT_IMP(a_char_legal, i_clk, i_rst_n, r_out_valid, r_out_char == CHAR_MINUS || (r_out_char >= CHAR_ZERO && r_out_char <= CHAR_NINE))
    `SIDA_ASSERT_IMP(a_mag_drained, i_clk, i_rst_n, i_cmd.align, r_mag == '0)
    `SIDA_ASSERT_NXT(a_idx_down, i_clk, i_rst_n, i_cmd.emit_digit && !o_sts.last_digit, r_dig_idx == $past(r_dig_idx) - 1'b1)

endmodule

### sv/sida_ctrl.sv
// controller: sequences load, conversion, alignment and character emission
// depends on sida_pkg, signed_int_to_decimal_ascii_assert.svh
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_ctrl import sida_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (i_sts.conv_done) begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                n_state = i_sts.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free && i_sts.last_digit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
            end
            S_ALIGN: begin
                o_cmd.align = 1'b1;
            end
            S_SIGN: begin
                o_cmd.emit_sign = i_sts.out_free;
            end
            S_DIGIT: begin
                o_cmd.emit_digit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    `SIDA_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, o_cmd.emit_digit && i_sts.last_digit, r_state == S_IDLE)
    `SIDA_ASSERT_NXT(a_neg_sign, i_clk, i_rst_n, r_state == S_ALIGN && i_sts.neg, r_state == S_SIGN)
    `SIDA_ASSERT_IMP(a_no_emit_idle, i_clk, i_rst_n, o_in_ready, !(o_cmd.emit_sign || o_cmd.emit_digit))

endmodule

### sv/signed_int_to_decimal_ascii.sv
// channel   dir  payload                        meaning
// i_in      in   value[31:0] signed             integer to print
// o_out     out  character[7:0], last           one ascii char per transfer, last on final
//
// top level of the signed integer to decimal ascii converter
// depends on sida_pkg, sida_if, sida_ctrl, sida_datapath
//
// an item goes through an accept state, the conversion state (4 bits per cycle through
// the shift-and-add-3 unit), an alignment state, then the sign and digit states, one
// character each while the output register is free; the conversion unit and the
// single output register set the pace
// synchronous active-low reset clears the state machine, the step counter and the output valid
// output stalls hold the character register; input ready is low until the
// last character is loaded into the output register
module signed_int_to_decimal_ascii import sida_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sida_value_if.sink  i_in,
    sida_char_if.source o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // input handshake goes to the controller, payload straight to the datapath
    assign i_in.ready = w_in_ready;

    sida_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // datapath owns the output register and drives the result channel
    sida_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_in.value),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

endmodule

### test/testbench.sv
// self-checking testbench for the signed integer to decimal ascii converter
// depends on sida_pkg, sida_if and signed_int_to_decimal_ascii; drives values,
// predicts the character stream and checks every output transfer
module testbench;
    import sida_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // longest stretch without any transfer before the run is declared hung;
    // the limit exceeds the long receiver hold-off plus the longest item
    localparam int STALL_LIMIT = 3000;
    // items sent with no idling at the end of the run
    localparam int CALM_TAIL   = 40;
    localparam int RANDOM_ITEMS = 310;
    // cycles to watch for stray characters once everything has arrived
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        bit                        drain_first; // hold until all output is back
    } t_pending_value;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_ascii_char;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sida_value_if in_if ();
    sida_char_if  out_if ();

    signed_int_to_decimal_ascii dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_pending_value pending_values[$];
    t_ascii_char    expected_chars[$];

    int error_count    = 0;
    int values_sent    = 0;
    int negatives_sent = 0;
    int chars_seen     = 0;

    // extremes, both signs, several digit counts and the most negative value
    int directed_values[] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -54321,
        999999999, 1000000000, -1000000000, 1234567890, -1234567890,
        2147483647, -2147483647, 32'h80000000, 32'h55555555, 32'hAAAAAAAA,
        32'h0F0F0F0F
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // decimal text of one value, most significant character first
    function automatic void expand_decimal(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits [NUM_DIGITS];
        int                 nd;
        t_ascii_char        c;
        mag = raw[VALUE_W-1] ? (32'd0 - raw) : raw; // unsigned, no overflow at -2^31
        nd  = 0;
        do begin
            digits[nd] = 4'(mag % 32'd10);
            mag        = mag / 32'd10;
            nd++;
        end while (mag != 0);
        if (raw[VALUE_W-1]) begin
            c.character = CHAR_MINUS;
            c.last      = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.character = CHAR_ZERO + CHAR_W'(digits[i]);
            c.last      = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    // mostly a random digit count with a random sign, plus raw words and
    // values close to both ends of the range
    function automatic logic signed [VALUE_W-1:0] random_value();
        int                kind;
        int                ndig;
        longint            scale;
        longint            lo;
        longint            hi;
        longint unsigned   r;
        longint            mag;
        longint            sval;
        kind = $urandom_range(9);
        if (kind < 2)
            return $urandom;
        if (kind == 2)
            return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(20)
                                     : 32'h80000000 + $urandom_range(20);
        ndig  = $urandom_range(10, 1);
        scale = 1;
        repeat (ndig - 1) scale = scale * 10;
        lo = (ndig == 1) ? 0 : scale;
        hi = scale * 10 - 1;
        if (hi > 64'sd2147483648)
            hi = 64'sd2147483648;
        r    = {$urandom, $urandom};
        mag  = lo + longint'(r % longint'(hi - lo + 1));
        sval = ($urandom_range(1) || mag == 64'sd2147483648) ? -mag : mag;
        return sval[VALUE_W-1:0];
    endfunction

    task automatic queue_value(input logic signed [VALUE_W-1:0] v, input bit drain);
        t_pending_value p;
        p.value       = v;
        p.drain_first = drain;
        pending_values.push_back(p);
    endtask

    // ---------------------------------------------------------------------
    // input driver: one value per transfer, random idle bursts, optional
    // pause until the output side has caught up
    // ---------------------------------------------------------------------
    int send_gap      = 0;
    int send_idle_pct = 20;

    always @(posedge i_clk) begin : drive_values
        bit             offer;
        bit             calm;
        t_pending_value p;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            offer = in_if.valid;
            calm  = pending_values.size() < CALM_TAIL;
            if (in_if.valid && in_if.ready) begin
                // transfer taken: predict its characters now
                expand_decimal(in_if.value);
                values_sent++;
                if (in_if.value[VALUE_W-1])
                    negatives_sent++;
                if (values_sent % 40 == 0)
                    send_idle_pct = ($urandom_range(2) == 0) ? 0 : 10 + $urandom_range(30);
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_values.size() > 0 &&
                             !(pending_values[0].drain_first && expected_chars.size() != 0)) begin
                    if (!calm && $urandom_range(99) < send_idle_pct) begin
                        // idle burst starts here; send_gap holds what remains of it
                        send_gap = $urandom_range(10, 1) - 1;
                    end else begin
                        p = pending_values.pop_front();
                        in_if.value <= p.value;
                        offer = 1'b1;
                    end
                end
            end
            in_if.valid <= offer;
        end
    end

    // ---------------------------------------------------------------------
    // output monitor: checks each character transfer against the oldest
    // prediction and throttles ready; one long hold-off fills the block
    // ---------------------------------------------------------------------
    int  recv_gap      = 0;
    int  recv_idle_pct = 20;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    always @(posedge i_clk) begin : check_chars
        t_ascii_char want;
        bit          calm;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            calm = pending_values.size() < CALM_TAIL;
            if (out_if.valid && out_if.ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected character transfer %h last %b",
                             $time, out_if.character, out_if.last);
                end else begin
                    want = expected_chars.pop_front();
                    if (out_if.character !== want.character) begin
                        error_count++;
                        $display("%0t: character mismatch, expected %h actual %h",
                                 $time, want.character, out_if.character);
                    end
                    if (out_if.last !== want.last) begin
                        error_count++;
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, want.last, out_if.last);
                    end
                end
                if (chars_seen % 100 == 0)
                    recv_idle_pct = ($urandom_range(2) == 0) ? 0 : 10 + $urandom_range(30);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!hold_done && chars_seen >= 300) begin
                // long back-pressure while the sender keeps offering
                hold_done = 1'b1;
                hold_left = 399;
                out_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(99) < recv_idle_pct) begin
                recv_gap = $urandom_range(10, 1) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: any transfer on either side restarts the count
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d characters outstanding",
                     $time, STALL_LIMIT, expected_chars.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------------
    initial begin
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        out_if.ready = 1'b0;

        foreach (directed_values[k])
            queue_value(directed_values[k], 1'b0);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            // twice the sender waits for the output to drain completely
            queue_value(random_value(), n == 100 || n == 230);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values.size() != 0 || in_if.valid || expected_chars.size() != 0)
            @(posedge i_clk);
        // stray characters after the last one would show up here
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d values (%0d negative) and %0d characters,",
                 values_sent, negatives_sent, chars_seen);
        $display("with idle bursts on both sides, a long output hold-off and drain pauses");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
